// File: hdl/tplm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplm_pkg
// Shared types, constants and control structs of the two-level page map.
// ----------------------------------------------------------------------------
package tplm_pkg;

    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int TABLE_SLOTS   = 8;

    localparam int IDX_W   = $clog2(DIR_ENTRIES);
    localparam int TIDX_W  = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int DIR_W   = 3 + SLOT_W;
    localparam int PTE_W   = 32;
    localparam int PTE_AW  = SLOT_W + TIDX_W;
    localparam int PTE_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int PAGE_W  = 20;
    localparam int OFF_W   = 12;
    localparam int CLR_W   = $clog2(PTE_DEPTH);

    typedef enum logic [1:0] {
        CMD_MAP       = 2'd0,
        CMD_UNMAP     = 2'd1,
        CMD_TRANSLATE = 2'd2,
        CMD_RANGE     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOSLOT = 2'd1,
        STAT_BAD    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DRD,
        S_DIR,
        S_PTE,
        S_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    clr_en;
        logic    accept;
        logic    dir_latch;
        logic    pte_exec;
        logic    advance;
        logic    res_load;
        t_status res_status;
        logic    out_load;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic dir_present;
        logic slot_free;
        t_cmd cmd;
        logic len_zero;
        logic range_ovf;
        logic pte_present;
        logic pte_user;
        logic page_last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: hdl/tplm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplm_in_if / tplm_out_if
// Valid/ready channels carrying page map requests and results.
// ----------------------------------------------------------------------------
interface tplm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] entry_flags;
    logic [31:0] range_length;

    modport source (output valid, cmd, virt_addr, phys_addr, entry_flags, range_length,
                    input ready);
    modport sink (input valid, cmd, virt_addr, phys_addr, entry_flags, range_length,
                  output ready);
endinterface

interface tplm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] phys_out;

    modport source (output valid, status, phys_out, input ready);
    modport sink (input valid, status, phys_out, output ready);
endinterface

// File: hdl/tplm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tplm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/tplm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplm_ctrl
// Command sequencer: clear pass, directory read, table access, range walk.
// ----------------------------------------------------------------------------
module tplm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tplm_pkg::t_dp_stat i_stat,
    output tplm_pkg::t_ctrl   o_ctrl
);
    import tplm_pkg::*;

    t_state  r_state, n_state;
    logic    w_dir_end;
    t_status w_dir_st;
    logic    w_pte_end;
    t_status w_pte_st;

    // decisions after the directory read and after the table read
    always_comb begin
        w_dir_end = 1'b0;
        w_dir_st  = STAT_OK;
        case (i_stat.cmd)
            CMD_MAP: begin
                if (!i_stat.dir_present && !i_stat.slot_free) begin
                    w_dir_end = 1'b1;
                    w_dir_st  = STAT_NOSLOT;
                end
            end
            CMD_RANGE: begin
                if (i_stat.len_zero) begin
                    w_dir_end = 1'b1;
                    w_dir_st  = STAT_OK;
                end else if (i_stat.range_ovf || !i_stat.dir_present) begin
                    w_dir_end = 1'b1;
                    w_dir_st  = STAT_BAD;
                end
            end
            default: begin
                if (!i_stat.dir_present) begin
                    w_dir_end = 1'b1;
                    w_dir_st  = STAT_BAD;
                end
            end
        endcase

        w_pte_end = 1'b1;
        w_pte_st  = STAT_OK;
        case (i_stat.cmd)
            CMD_TRANSLATE: w_pte_st = i_stat.pte_present ? STAT_OK : STAT_BAD;
            CMD_RANGE: begin
                if (!(i_stat.pte_present && i_stat.pte_user)) begin
                    w_pte_st = STAT_BAD;
                end else if (!i_stat.page_last) begin
                    w_pte_end = 1'b0;
                end
            end
            default: w_pte_st = STAT_OK;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_stat.clr_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_DIR;
            S_DRD:   n_state = S_DIR;
            S_DIR:   n_state = w_dir_end ? S_RESP : S_PTE;
            S_PTE:   n_state = w_pte_end ? S_RESP : S_DRD;
            S_RESP:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_ctrl.res_status = STAT_OK;
        case (r_state)
            S_CLEAR: o_ctrl.clr_en = 1'b1;
            S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.accept   = i_in_valid;
            end
            S_DIR: begin
                o_ctrl.dir_latch  = !w_dir_end;
                o_ctrl.res_load   = w_dir_end;
                o_ctrl.res_status = w_dir_st;
            end
            S_PTE: begin
                o_ctrl.pte_exec   = 1'b1;
                o_ctrl.advance    = !w_pte_end;
                o_ctrl.res_load   = w_pte_end;
                o_ctrl.res_status = w_pte_st;
            end
            S_RESP: o_ctrl.out_load = i_stat.out_free;
            default: o_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hdl/tplm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tplm_dp
// Directory and table memories, slot pool, present counts and result path.
// ----------------------------------------------------------------------------
module tplm_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tplm_pkg::t_ctrl    i_ctrl,
    input  logic [1:0]         i_cmd,
    input  logic [31:0]        i_virt_addr,
    input  logic [31:0]        i_phys_addr,
    input  logic [11:0]        i_entry_flags,
    input  logic [31:0]        i_range_length,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [31:0]        o_phys_out,
    output tplm_pkg::t_dp_stat o_stat
);
    import tplm_pkg::*;

    t_cmd              r_cmd;
    logic [OFF_W-1:0]  r_off;
    logic [PAGE_W-1:0] r_frame;
    logic [11:0]       r_flags;
    logic              r_len_zero;
    logic              r_ovf;
    logic [PAGE_W-1:0] r_last;
    logic [PAGE_W-1:0] r_page;
    logic [SLOT_W-1:0] r_slot;
    logic              r_alloc;
    logic [TABLE_SLOTS-1:0] r_used;
    logic [CNT_W-1:0]  r_cnt [TABLE_SLOTS];
    logic [CLR_W-1:0]  r_clr;
    t_status           r_res_status;
    logic [31:0]       r_res_phys;
    logic              r_out_valid;
    logic [1:0]        r_out_status;
    logic [31:0]       r_out_phys;

    logic [32:0]       w_sum;
    logic [31:0]       w_end;
    logic [DIR_W-1:0]  w_dir_q, w_dir_wd;
    logic [IDX_W-1:0]  w_dir_ra, w_dir_wa;
    logic              w_dir_we;
    logic [PTE_W-1:0]  w_pte_q, w_pte_wd;
    logic [PTE_AW-1:0] w_pte_ra, w_pte_wa;
    logic              w_pte_we;
    logic              w_free_any;
    logic [SLOT_W-1:0] w_free_slot, w_slot_sel;
    logic [CNT_W-1:0]  w_cnt, w_cnt_n;
    logic              w_was, w_now, w_release;

    tplm_ram #(.WIDTH(DIR_W), .DEPTH(DIR_ENTRIES)) u_dir (
        .i_clk   (i_clk),
        .i_we    (w_dir_we),
        .i_waddr (w_dir_wa),
        .i_wdata (w_dir_wd),
        .i_raddr (w_dir_ra),
        .o_rdata (w_dir_q)
    );

    tplm_ram #(.WIDTH(PTE_W), .DEPTH(PTE_DEPTH)) u_pte (
        .i_clk   (i_clk),
        .i_we    (w_pte_we),
        .i_waddr (w_pte_wa),
        .i_wdata (w_pte_wd),
        .i_raddr (w_pte_ra),
        .o_rdata (w_pte_q)
    );

    assign w_sum = {1'b0, i_virt_addr} + {1'b0, i_range_length};
    assign w_end = w_sum[31:0] - 32'd1;

    // lowest free slot
    always_comb begin
        w_free_any  = 1'b0;
        w_free_slot = '0;
        for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                w_free_any  = 1'b1;
                w_free_slot = SLOT_W'(s);
            end
        end
    end

    assign w_slot_sel = w_dir_q[0] ? w_dir_q[DIR_W-1:3] : w_free_slot;

    assign w_dir_ra = i_ctrl.accept ? i_virt_addr[31:32-IDX_W] : r_page[PAGE_W-1:PAGE_W-IDX_W];
    assign w_pte_ra = {w_slot_sel, r_page[TIDX_W-1:0]};

    // present count bookkeeping for the entry being written
    assign w_cnt = r_cnt[r_slot];
    assign w_was = w_pte_q[0];
    assign w_now = (r_cmd == CMD_MAP) ? r_flags[0] : 1'b0;
    always_comb begin
        w_cnt_n = w_cnt;
        if (w_was && !w_now && (w_cnt != '0)) begin
            w_cnt_n = w_cnt - CNT_W'(1);
        end else if (!w_was && w_now) begin
            w_cnt_n = w_cnt + CNT_W'(1);
        end
    end
    assign w_release = i_ctrl.pte_exec && (r_cmd == CMD_UNMAP) && (w_cnt_n == '0);

    always_comb begin
        w_pte_we = 1'b0;
        w_pte_wa = {r_slot, r_page[TIDX_W-1:0]};
        w_pte_wd = '0;
        w_dir_we = 1'b0;
        w_dir_wa = r_page[PAGE_W-1:PAGE_W-IDX_W];
        w_dir_wd = '0;
        if (i_ctrl.clr_en) begin
            w_pte_we = 1'b1;
            w_pte_wa = r_clr;
            w_dir_we = 1'b1;
            w_dir_wa = r_clr[IDX_W-1:0];
        end else if (i_ctrl.pte_exec && (r_cmd == CMD_MAP)) begin
            w_pte_we = 1'b1;
            w_pte_wd = {r_frame, r_flags};
            w_dir_we = r_alloc;
            w_dir_wd = {r_slot, r_flags[2:1], 1'b1};
        end else if (i_ctrl.pte_exec && (r_cmd == CMD_UNMAP)) begin
            w_pte_we = 1'b1;
            w_dir_we = w_release;
        end
    end

    // request fields and walk position
    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd      <= t_cmd'(i_cmd);
            r_off      <= i_virt_addr[OFF_W-1:0];
            r_frame    <= i_phys_addr[31:OFF_W];
            r_flags    <= i_entry_flags;
            r_len_zero <= (i_range_length == 32'd0);
            r_ovf      <= w_sum[32];
            r_last     <= w_end[31:OFF_W];
            r_page     <= i_virt_addr[31:OFF_W];
        end else if (i_ctrl.advance) begin
            r_page <= r_page + PAGE_W'(1);
        end
        if (i_ctrl.dir_latch) begin
            r_slot  <= w_slot_sel;
            r_alloc <= !w_dir_q[0];
        end
        if (i_ctrl.res_load) begin
            r_res_status <= i_ctrl.res_status;
            r_res_phys   <= (i_ctrl.res_status == STAT_OK && r_cmd == CMD_TRANSLATE) ?
                            {w_pte_q[31:OFF_W], r_off} : 32'd0;
        end
        if (i_ctrl.out_load) begin
            r_out_status <= r_res_status;
            r_out_phys   <= r_res_phys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                r_cnt[s] <= '0;
            end
        end else begin
            if (i_ctrl.clr_en) begin
                r_clr <= r_clr + CLR_W'(1);
            end
            if (i_ctrl.pte_exec && (r_cmd == CMD_MAP || r_cmd == CMD_UNMAP)) begin
                r_cnt[r_slot] <= w_cnt_n;
            end
            if (i_ctrl.pte_exec && (r_cmd == CMD_MAP) && r_alloc) begin
                r_used[r_slot] <= 1'b1;
            end else if (w_release) begin
                r_used[r_slot] <= 1'b0;
            end
            if (i_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_phys_out  = r_out_phys;

    assign o_stat.clr_done    = (r_clr == CLR_W'(PTE_DEPTH - 1));
    assign o_stat.dir_present = w_dir_q[0];
    assign o_stat.slot_free   = w_free_any;
    assign o_stat.cmd         = r_cmd;
    assign o_stat.len_zero    = r_len_zero;
    assign o_stat.range_ovf   = r_ovf;
    assign o_stat.pte_present = w_pte_q[0];
    assign o_stat.pte_user    = w_pte_q[2];
    assign o_stat.page_last   = (r_page == r_last);
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

endmodule

// File: hdl/two_level_page_table_manager_core.sv
`timescale 1ns / 1ps
// sequence: a request passes S_DIR, S_PTE and S_RESP on its way to the output register;
//   S_PTE is skipped when the directory read ends the request (entry absent, no free slot, range
//   of zero length or overflowing); a range check walks S_DRD, S_DIR and S_PTE per extra page
// requests: one at a time; a new one is taken only once the result has moved to the output register
// reset: synchronous; a clearing pass over all 8192 table entries zeroes both memories, no
//   request is taken until it finishes
// ----------------------------------------------------------------------------
// two_level_page_table_manager_core
// Two-level page map with slot pool: map, unmap, translate, user range check.
// ----------------------------------------------------------------------------
module two_level_page_table_manager_core (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tplm_in_if.sink  i_in,
    tplm_out_if.source o_out
);
    import tplm_pkg::*;

    t_ctrl    w_ctrl;
    t_dp_stat w_stat;

    tplm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    tplm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_cmd          (i_in.cmd),
        .i_virt_addr    (i_in.virt_addr),
        .i_phys_addr    (i_in.phys_addr),
        .i_entry_flags  (i_in.entry_flags),
        .i_range_length (i_in.range_length),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_status       (o_out.status),
        .o_phys_out     (o_out.phys_out),
        .o_stat         (w_stat)
    );

    assign i_in.ready = w_ctrl.in_ready;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("transfer accepted while a request is in progress");

    a_phys_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.phys_out != 32'd0) |-> (o_out.status == STAT_OK))
        else $error("nonzero address with failing status");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.clr_en |-> (!w_ctrl.res_load && !w_ctrl.pte_exec))
        else $error("table access during clearing pass");

endmodule
